>>> hdl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and constants of the prefix trie engine: default pool
// geometry, operation codes, stream field widths and internal structs.
// ----------------------------------------------------------------------------
package pte_pkg;

    // Default pool geometry
    localparam int NODE_COUNT_DEF    = 1024;
    localparam int ALPHABET_SIZE_DEF = 26;

    // Field widths fixed by the stream format
    localparam int OP_W         = 2;
    localparam int LETTER_W     = 5;
    localparam int NODES_USED_W = 11;
    localparam int S_TDATA_W    = 8;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 16;
    localparam int M_PAD_W      = M_TDATA_W - NODES_USED_W - 2;
    localparam int S_PAD_W      = S_TDATA_W - LETTER_W - 1;

    // Width used to range-check a letter against the alphabet (holds 256)
    localparam int LCMP_W = 9;

    // Operation codes; any other code acts as prefix search
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

    // One result word
    typedef struct packed {
        logic [NODES_USED_W-1:0] nodes_used;
        logic                    pool_full;
        logic                    found;
    } result_t;

    // Access strobes of one memory port
    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

endpackage

>>> hdl/pte_ram.sv
// ----------------------------------------------------------------------------
// pte_ram
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module pte_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  pte_pkg::ram_ctl_t  ctl,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [DATA_W-1:0]  wdata,
    output logic [DATA_W-1:0]  rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[addr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pte_walk.sv
// ----------------------------------------------------------------------------
// pte_walk
// Trie walk sequencer: clears both memories after reset, then steps one
// letter per word through a child-link read, allocating nodes on insert,
// and sets the terminal mark on a good insert or reads it on an exact search.
// ----------------------------------------------------------------------------
module pte_walk #(
    parameter int NODE_COUNT    = pte_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = pte_pkg::ALPHABET_SIZE_DEF,
    parameter int NODE_W        = $clog2(NODE_COUNT),
    parameter int SLOT_W        = $clog2(NODE_COUNT * ALPHABET_SIZE)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input word
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pte_pkg::OP_W-1:0]      in_op,
    input  logic [pte_pkg::LETTER_W-1:0]  in_letter,
    input  logic                          in_first,
    input  logic                          in_last,
    input  logic                          in_no_letter,
    // result handoff
    input  logic                          out_free,
    output logic                          res_load,
    output pte_pkg::result_t              res,
    // child-link memory
    output pte_pkg::ram_ctl_t             link_ctl,
    output logic [SLOT_W-1:0]             link_addr,
    output logic [NODE_W-1:0]             link_wdata,
    input  logic [NODE_W-1:0]             link_rdata,
    // terminal-mark memory
    output pte_pkg::ram_ctl_t             mark_ctl,
    output logic [NODE_W-1:0]             mark_addr,
    output logic                          mark_wdata,
    input  logic                          mark_rdata
);

    localparam int TOTAL = NODE_COUNT * ALPHABET_SIZE;
    localparam int NF_W  = $clog2(NODE_COUNT + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FIN,
        ST_RES
    } state_t;

    state_t                      state_reg, state_next;
    logic [SLOT_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]           walk_reg, walk_next;
    logic                        failed_reg, failed_next;
    logic                        ovf_reg, ovf_next;
    logic [NF_W-1:0]             next_free_reg, next_free_next;
    logic [pte_pkg::OP_W-1:0]    op_reg, op_next;
    logic                        last_reg, last_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;

    logic [NODE_W-1:0]           node_eff;
    logic                        failed_eff;
    logic                        ovf_eff;
    logic                        letter_bad;
    logic [SLOT_W-1:0]           slot_calc;

    // Walk state as seen by the arriving word; first restarts at the root
    assign node_eff   = in_first ? '0 : walk_reg;
    assign failed_eff = in_first ? 1'b0 : failed_reg;
    assign ovf_eff    = in_first ? 1'b0 : ovf_reg;
    assign letter_bad = pte_pkg::LCMP_W'(in_letter) >= pte_pkg::LCMP_W'(ALPHABET_SIZE);
    assign slot_calc  = SLOT_W'(SLOT_W'(node_eff) * SLOT_W'(ALPHABET_SIZE))
                      + SLOT_W'(in_letter);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        walk_next      = walk_reg;
        failed_next    = failed_reg;
        ovf_next       = ovf_reg;
        next_free_next = next_free_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;

        s_tready       = 1'b0;
        res_load       = 1'b0;
        res.found      = 1'b0;
        res.pool_full  = 1'b0;
        res.nodes_used = pte_pkg::NODES_USED_W'(next_free_reg);

        link_ctl       = '0;
        link_addr      = slot_calc;
        link_wdata     = NODE_W'(next_free_reg);
        mark_ctl       = '0;
        mark_addr      = walk_reg;
        mark_wdata     = 1'b1;

        case (state_reg)
            // Sweep zeros through both memories
            ST_CLEAR: begin
                link_ctl.we = 1'b1;
                link_addr   = clr_cnt_reg;
                link_wdata  = '0;
                mark_ctl.we = 1'b1;
                mark_addr   = NODE_W'(clr_cnt_reg);
                mark_wdata  = 1'b0;
                if (clr_cnt_reg == SLOT_W'(TOTAL - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // Take a word and start its child-link lookup if its letter is valid and the walk has not failed
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next     = in_op;
                    last_next   = in_last;
                    walk_next   = node_eff;
                    failed_next = failed_eff;
                    ovf_next    = ovf_eff;
                    slot_next   = slot_calc;
                    if (!in_no_letter && !failed_eff && !letter_bad) begin
                        link_ctl.re = 1'b1;
                        state_next  = ST_LOOK;
                    end else begin
                        if (!in_no_letter && letter_bad) begin
                            failed_next = 1'b1;
                        end
                        state_next = in_last ? ST_FIN : ST_IDLE;
                    end
                end
            end

            // Follow the link, or allocate a fresh node on insert while the pool has room; else mark the walk failed
            ST_LOOK: begin
                link_addr = slot_reg;
                if (link_rdata != '0) begin
                    walk_next = link_rdata;
                end else if (op_reg != pte_pkg::OP_INSERT) begin
                    failed_next = 1'b1;
                end else if (next_free_reg < NF_W'(NODE_COUNT)) begin
                    link_ctl.we    = 1'b1;
                    walk_next      = NODE_W'(next_free_reg);
                    next_free_next = next_free_reg + 1'b1;
                end else begin
                    ovf_next    = 1'b1;
                    failed_next = 1'b1;
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end

            // Close the word once the result slot is free
            ST_FIN: begin
                if (out_free) begin
                    case (op_reg)
                        pte_pkg::OP_INSERT: begin
                            mark_ctl.we   = !failed_reg;
                            res.found     = !failed_reg;
                            res.pool_full = failed_reg && ovf_reg;
                            res_load      = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        pte_pkg::OP_SEARCH: begin
                            if (failed_reg) begin
                                res_load   = 1'b1;
                                state_next = ST_IDLE;
                            end else begin
                                mark_ctl.re = 1'b1;
                                state_next  = ST_RES;
                            end
                        end
                        default: begin
                            res.found  = !failed_reg;
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Report the terminal mark of the reached node
            ST_RES: begin
                res.found  = mark_rdata;
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and walk registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            walk_reg      <= '0;
            failed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            next_free_reg <= NF_W'(1);
            op_reg        <= pte_pkg::OP_INSERT;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            walk_reg      <= walk_next;
            failed_reg    <= failed_next;
            ovf_reg       <= ovf_next;
            next_free_reg <= next_free_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
        end
        slot_reg <= slot_next;
    end

`ifndef SYNTHESIS
    // The walk only ever stands on an allocated node
    a_walk_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        NF_W'(walk_reg) < next_free_reg)
        else $error("walk node beyond allocated pool");

    // The allocation counter never passes the pool size
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= NF_W'(NODE_COUNT))
        else $error("allocation counter past pool size");

    // A link is written during the walk only where none existed
    a_link_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK && link_ctl.we) |-> (link_rdata == '0))
        else $error("overwriting an existing child link");

    // A result is only handed over into a free output slot
    a_res_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded while output slot busy");

    // No word is taken during the clearing sweep
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("left clearing sweep into a walk state");
`endif

endmodule

>>> hdl/prefix_trie_engine_unit.sv
// ----------------------------------------------------------------------------
// prefix_trie_engine_unit
// Lower-case word trie in a bounded node pool, fed one letter per word.
// ----------------------------------------------------------------------------
// Usage
//   Input words (s_*) carry one letter each, tagged by operation in tuser:
//   insert, exact search or prefix search. tdata[5] marks the first letter
//   of a word, s_tlast the last one; the last letter yields one result word
//   on m_* with found, pool_full and the count of nodes in use.
//   An empty word is a single word with first, last and no_letter set.
// Sequence
//   After reset the child-link and terminal-mark memories are swept to
//   zero, every link entry and every mark; the block holds s_tready low
//   during the sweep.
//   A letter is accepted, then its child-link memory read decides the
//   node the next letter starts from; no letter is taken until then.
//   A letterless word is only accepted. A word end adds a finishing
//   step, plus a terminal-mark read for an exact search that reached a
//   node; the result is then in the output register.
// Back-pressure
//   The output register holds a result while m_tready is low; the next
//   word's letters are still taken, and its end waits for the register.
// ----------------------------------------------------------------------------
module prefix_trie_engine_unit #(
    parameter int NODE_COUNT    = pte_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = pte_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pte_pkg::S_TDATA_W-1:0]     s_tdata,  // letter[4:0], first[5], zero pad
    input  logic                              s_tlast,  // last letter of the word
    input  logic [pte_pkg::S_TUSER_W-1:0]     s_tuser,  // operation[1:0], no_letter[2]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pte_pkg::M_TDATA_W-1:0]     m_tdata   // found[0], pool_full[1],
                                                        // nodes_used[12:2], zero pad
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int SLOT_W = $clog2(NODE_COUNT * ALPHABET_SIZE);

    pte_pkg::ram_ctl_t   link_ctl;
    logic [SLOT_W-1:0]   link_addr;
    logic [NODE_W-1:0]   link_wdata;
    logic [NODE_W-1:0]   link_rdata;
    pte_pkg::ram_ctl_t   mark_ctl;
    logic [NODE_W-1:0]   mark_addr;
    logic                mark_wdata;
    logic                mark_rdata;

    logic                res_load;
    pte_pkg::result_t    res;
    pte_pkg::result_t    res_reg;
    logic                m_tvalid_reg;
    logic                out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    pte_walk #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .NODE_W        (NODE_W),
        .SLOT_W        (SLOT_W)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .in_op        (s_tuser[pte_pkg::OP_W-1:0]),
        .in_letter    (s_tdata[pte_pkg::LETTER_W-1:0]),
        .in_first     (s_tdata[pte_pkg::LETTER_W]),
        .in_last      (s_tlast),
        .in_no_letter (s_tuser[pte_pkg::OP_W]),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res),
        .link_ctl     (link_ctl),
        .link_addr    (link_addr),
        .link_wdata   (link_wdata),
        .link_rdata   (link_rdata),
        .mark_ctl     (mark_ctl),
        .mark_addr    (mark_addr),
        .mark_wdata   (mark_wdata),
        .mark_rdata   (mark_rdata)
    );

    // Child links: one entry per node and letter
    pte_ram #(
        .DEPTH  (NODE_COUNT * ALPHABET_SIZE),
        .DATA_W (NODE_W),
        .ADDR_W (SLOT_W)
    ) u_link_ram (
        .aclk  (aclk),
        .ctl   (link_ctl),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    // Terminal marks: one bit per node
    pte_ram #(
        .DEPTH  (NODE_COUNT),
        .DATA_W (1),
        .ADDR_W (NODE_W)
    ) u_mark_ram (
        .aclk  (aclk),
        .ctl   (mark_ctl),
        .addr  (mark_addr),
        .wdata (mark_wdata),
        .rdata (mark_rdata)
    );

    // Hold the result word until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{pte_pkg::M_PAD_W{1'b0}}, res_reg.nodes_used,
                       res_reg.pool_full, res_reg.found};

endmodule
